// ----- design/fpd_pkg.sv -----
// Package for the flight phase detector.
// Holds the phase enum, the configuration register set and its reset values.
// No dependencies.
package fpd_pkg;

  localparam int AccelW     = 16;
  localparam int AltW       = 24;
  localparam int AccelThrW  = 15;
  localparam int AltThrW    = 23;
  localparam int CountW     = 8;
  localparam int CfgIndexW  = 3;
  localparam int CfgDataW   = 32;
  localparam int InDataW    = 40;
  localparam int OutDataW   = 8;

  localparam logic [AccelThrW-1:0] AccelThrReset   = 15'd3766;
  localparam logic [AltThrW-1:0]   LaunchAltReset  = 23'd400;
  localparam logic [AltThrW-1:0]   MainAltReset    = 23'd8000;
  localparam logic [CountW-1:0]    CoastCntReset   = 8'd100;
  localparam logic [CountW-1:0]    ApogeeCntReset  = 8'd10;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_ACCEL_THR  = 3'd0,
    CFG_LAUNCH_ALT = 3'd1,
    CFG_MAIN_ALT   = 3'd2,
    CFG_COAST_CNT  = 3'd3,
    CFG_APOGEE_CNT = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_BOOST   = 3'd1,
    PH_BURNOUT = 3'd2,
    PH_COAST   = 3'd3,
    PH_APOGEE  = 3'd4,
    PH_DROGUE  = 3'd5,
    PH_MAIN    = 3'd6,
    PH_LANDED  = 3'd7
  } phase_t;

  typedef struct packed {
    logic [AccelThrW-1:0] accel_threshold;
    logic [AltThrW-1:0]   launch_altitude;
    logic [AltThrW-1:0]   main_deploy_altitude;
    logic [CountW-1:0]    coast_confirm_count;
    logic [CountW-1:0]    apogee_confirm_count;
  } cfg_t;

endpackage

// ----- design/flight_phase_detector.sv -----
// Flight phase detector top level: input register, phase sequencer,
// result register and configuration port. Depends on fpd_pkg,
// fpd_cfg_regs and fpd_phase_core.
//
// Usage:
//   in_*  : sensor samples, one beat per sample. in_tdata[15:0] is accel_z
//           (signed, 1/128 m/s^2), in_tdata[39:16] is altitude (signed, 1/8 ft).
//   out_* : one beat per sample. out_tdata[2:0] is the phase after the sample
//           (0 idle .. 7 landed), out_tdata[3] is set when the sample changed
//           the phase; upper bits are zero.
//   cfg_* : register writes, always ready. Index 0 accel threshold, 1 launch
//           altitude, 2 main deploy altitude, 3 coast confirm count, 4 apogee
//           confirm count; other indexes are ignored. Write only while idle.
// A sample passes the input register, then the result register. One sample per
// cycle is sustained while out_tready is high; the phase update is combinational
// compare logic between the input register and the result register.
// Reset (rst_n low, synchronous) loads default thresholds, phase idle, zero
// streaks and zero previous altitude, and empties both registers.
// When out_tready is low the result holds; the input register still takes
// one more beat, then in_tready drops until the result is taken.
module flight_phase_detector import fpd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [InDataW-1:0]   in_tdata,   // accel_z[15:0], altitude[39:16]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OutDataW-1:0]  out_tdata,  // flight_phase[2:0], phase_entered[3]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  cfg_t cfg;

  logic                     s1_valid_r, s1_valid_nxt;
  logic signed [AccelW-1:0] s1_accel_r;
  logic signed [AltW-1:0]   s1_alt_r;
  logic                     out_valid_r, out_valid_nxt;
  phase_t                   out_phase_r;
  logic                     out_entered_r;

  logic   advance, step;
  phase_t phase_next;
  logic   phase_entered;

  assign cfg_ready = 1'b1;

  fpd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign advance   = !out_valid_r || out_tready;
  assign step      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  assign s1_valid_nxt  = in_tready ? in_tvalid : s1_valid_r;
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  fpd_phase_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .accel_z       (s1_accel_r),
    .altitude      (s1_alt_r),
    .cfg           (cfg),
    .phase_next    (phase_next),
    .phase_entered (phase_entered)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_accel_r <= $signed(in_tdata[AccelW-1:0]);
      s1_alt_r   <= $signed(in_tdata[AccelW+AltW-1:AccelW]);
    end
    if (step) begin
      out_phase_r   <= phase_next;
      out_entered_r <= phase_entered;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_entered_r, out_phase_r};

endmodule

// ----- design/fpd_cfg_regs.sv -----
// Configuration register file of the flight phase detector.
// Depends on fpd_pkg.
module fpd_cfg_regs import fpd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CfgIndexW-1:0] wr_index,
  input  logic [CfgDataW-1:0]  wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_index_t'(wr_index))
        CFG_ACCEL_THR:  cfg_nxt.accel_threshold      = wr_data[AccelThrW-1:0];
        CFG_LAUNCH_ALT: cfg_nxt.launch_altitude      = wr_data[AltThrW-1:0];
        CFG_MAIN_ALT:   cfg_nxt.main_deploy_altitude = wr_data[AltThrW-1:0];
        CFG_COAST_CNT:  cfg_nxt.coast_confirm_count  = wr_data[CountW-1:0];
        CFG_APOGEE_CNT: cfg_nxt.apogee_confirm_count = wr_data[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_threshold      <= AccelThrReset;
      cfg_r.launch_altitude      <= LaunchAltReset;
      cfg_r.main_deploy_altitude <= MainAltReset;
      cfg_r.coast_confirm_count  <= CoastCntReset;
      cfg_r.apogee_confirm_count <= ApogeeCntReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/fpd_phase_core.sv -----
// Phase sequencer: phase state, confirm streaks and previous altitude.
// Decides the next phase for one registered sample. Depends on fpd_pkg.
module fpd_phase_core import fpd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic signed [AccelW-1:0] accel_z,
  input  logic signed [AltW-1:0]   altitude,
  input  cfg_t                   cfg,
  output phase_t                 phase_next,
  output logic                   phase_entered
);

  phase_t                 phase_r, phase_nxt;
  logic [CountW-1:0]      coast_streak_r, coast_streak_nxt;
  logic [CountW-1:0]      apogee_streak_r, apogee_streak_nxt;
  logic signed [AltW-1:0] last_alt_r, last_alt_nxt;

  logic signed [AccelW-1:0] at_s;
  logic signed [AltW-1:0]   la_s, md_s;
  logic                     a_gt_at, a_lt_at, h_gt_la, h_lt_la, h_lt_md;
  logic                     h_gt_prev, h_lt_prev;
  logic [CountW-1:0]        coast_bump, apogee_bump;

  assign at_s      = $signed({1'b0, cfg.accel_threshold});
  assign la_s      = $signed({1'b0, cfg.launch_altitude});
  assign md_s      = $signed({1'b0, cfg.main_deploy_altitude});
  assign a_gt_at   = accel_z > at_s;
  assign a_lt_at   = accel_z < at_s;
  assign h_gt_la   = altitude > la_s;
  assign h_lt_la   = altitude < la_s;
  assign h_lt_md   = altitude < md_s;
  assign h_gt_prev = altitude > last_alt_r;
  assign h_lt_prev = altitude < last_alt_r;

  // saturating increments
  assign coast_bump  = (&coast_streak_r)  ? coast_streak_r  : coast_streak_r + 1'b1;
  assign apogee_bump = (&apogee_streak_r) ? apogee_streak_r : apogee_streak_r + 1'b1;

  // next state
  always_comb begin
    phase_nxt         = phase_r;
    coast_streak_nxt  = coast_streak_r;
    apogee_streak_nxt = apogee_streak_r;
    case (phase_r)
      PH_IDLE: begin
        if (a_gt_at || h_gt_la) phase_nxt = PH_BOOST;
      end
      PH_BOOST: begin
        if (a_lt_at || h_gt_prev) phase_nxt = PH_BURNOUT;
      end
      PH_BURNOUT: begin
        if (a_lt_at) begin
          if (coast_bump >= cfg.coast_confirm_count) begin
            phase_nxt        = PH_COAST;
            coast_streak_nxt = '0;
          end else begin
            coast_streak_nxt = coast_bump;
          end
        end else begin
          coast_streak_nxt = '0;
        end
      end
      PH_COAST: begin
        if (h_lt_prev) begin
          if (apogee_bump >= cfg.apogee_confirm_count) begin
            phase_nxt         = PH_APOGEE;
            apogee_streak_nxt = '0;
          end else begin
            apogee_streak_nxt = apogee_bump;
          end
        end else begin
          apogee_streak_nxt = '0;
        end
      end
      PH_APOGEE: begin
        phase_nxt = PH_DROGUE;
      end
      PH_DROGUE: begin
        if (h_lt_md) phase_nxt = PH_MAIN;
      end
      PH_MAIN: begin
        if (a_lt_at || h_lt_la) phase_nxt = PH_LANDED;
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    phase_next    = phase_nxt;
    phase_entered = (phase_nxt != phase_r);
    last_alt_nxt  = altitude;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      coast_streak_r  <= '0;
      apogee_streak_r <= '0;
      last_alt_r      <= '0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      coast_streak_r  <= coast_streak_nxt;
      apogee_streak_r <= apogee_streak_nxt;
      last_alt_r      <= last_alt_nxt;
    end
  end

  a_landed_holds: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_LANDED |=> phase_r == PH_LANDED)
    else $error("landed phase left");

  a_apogee_to_drogue: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_APOGEE |=> phase_r == PH_DROGUE)
    else $error("apogee not followed by drogue");

  a_idle_exit: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_IDLE |=> phase_r == PH_IDLE || phase_r == PH_BOOST)
    else $error("idle left to a phase other than boost");

  a_alt_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> last_alt_r == $past(altitude))
    else $error("previous altitude not updated");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r) && $stable(coast_streak_r) && $stable(apogee_streak_r))
    else $error("state moved without a sample");

endmodule
